FILE: rtl/tagged_int_sum_product_reduce_macros.svh
// assertion macros for the tagged integer sum/product reduction block
`ifndef TAGGED_INT_SUM_PRODUCT_REDUCE_MACROS_SVH
`define TAGGED_INT_SUM_PRODUCT_REDUCE_MACROS_SVH

// same-cycle implication, disabled during reset
`define TISP_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define TISP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/tisp_pkg.sv
// shared types and constants of the tagged integer sum/product reduction block
package tisp_pkg;

   localparam int IN_VALUE_WIDTH = 32;
   localparam int KIND_WIDTH     = 3;
   localparam int QUEUE_DEPTH    = 2;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_NORMAL  = 3'd0,
      KIND_INF     = 3'd1,
      KIND_UNKNOWN = 3'd2,
      KIND_NULL    = 3'd3,
      KIND_ERROR   = 3'd4
   } kind_type;

   typedef enum logic [3:0] {
      PHASE_FINITE = 4'b0001,
      PHASE_ZERO   = 4'b0010,
      PHASE_INF    = 4'b0100,
      PHASE_DONE   = 4'b1000
   } phase_type;

   typedef enum logic {
      OP_SUM     = 1'b0,
      OP_PRODUCT = 1'b1
   } op_type;

   // classified control part of one operand
   typedef struct packed {
      op_type   op;
      kind_type kind;
      logic     inf_neg;
      logic     is_zero;
      logic     first;
      logic     last;
   } ctl_type;

   localparam int CTL_WIDTH = $bits(ctl_type);
   localparam int RSP_WIDTH = KIND_WIDTH + IN_VALUE_WIDTH;

endpackage

FILE: rtl/tagged_int_sum_product_reduce.sv
// top level of the tagged integer sum/product reduction block
// usage:
//   input side is a queue: drive the req_ fields with req_push high; the item
//   is taken on a clock edge where req_full is low
//   req_first_operand starts a run and samples req_operation (sum or product)
//   req_last_operand ends the run; exactly one result item comes out for it
//   result side is a queue: while rsp_empty is low the oldest result is on
//   rsp_result_kind / rsp_result_value; pulse rsp_pop to take it
// path: a last item is written into the middle queue at the edge that takes it
//   (front classify), and the back step then moves it into the result queue,
//   from which it shows up on the result ports
// throughput: 1 item per cycle while the result queue has room; the back stage
//   does one add or one multiply on the accumulator per cycle, and that loop sets the rate
// stall: when the result queue is full the back stage holds a last item, the
//   2-entry middle queue fills and req_full rises; nothing is dropped
// reset: synchronous, clears both queues and the run state (finite phase,
//   zero accumulator, sum); an item with no first mark continues a sum from 0
module tagged_int_sum_product_reduce #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // input item channel
   input  logic                                      req_push,
   output logic                                      req_full,
   input  logic                                      req_operation,
   input  logic [tisp_pkg::KIND_WIDTH-1:0]           req_operand_kind,
   input  logic signed [tisp_pkg::IN_VALUE_WIDTH-1:0] req_operand_value,
   input  logic                                      req_first_operand,
   input  logic                                      req_last_operand,
   // result item channel
   output logic                                      rsp_empty,
   input  logic                                      rsp_pop,
   output logic [tisp_pkg::KIND_WIDTH-1:0]           rsp_result_kind,
   output logic signed [tisp_pkg::IN_VALUE_WIDTH-1:0] rsp_result_value
);

   localparam int MID_WIDTH = tisp_pkg::CTL_WIDTH + VALUE_WIDTH;

   // classified item from the front stage
   tisp_pkg::ctl_type              front_ctl;
   logic [VALUE_WIDTH-1:0]         front_value;

   // middle queue output seen by the back stage
   logic [MID_WIDTH-1:0]           mid_rd;
   logic                           mid_empty;
   tisp_pkg::ctl_type              back_ctl;
   logic [VALUE_WIDTH-1:0]         back_value;
   logic                           back_take;

   // result from the back stage
   logic                           res_push, res_full;
   tisp_pkg::kind_type             res_kind;
   logic [tisp_pkg::IN_VALUE_WIDTH-1:0] res_value;
   logic [tisp_pkg::RSP_WIDTH-1:0] rsp_rd;

   tisp_front #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_front (
      .operation     (req_operation),
      .operand_kind  (req_operand_kind),
      .operand_value (req_operand_value),
      .first_operand (req_first_operand),
      .last_operand  (req_last_operand),
      .ctl           (front_ctl),
      .value         (front_value)
   );

   // decouples the front from the back stage
   tisp_queue #(
      .WIDTH (MID_WIDTH),
      .DEPTH (tisp_pkg::QUEUE_DEPTH)
   ) u_mid_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .full    (req_full),
      .wr_data ({front_ctl, front_value}),
      .pop     (back_take),
      .empty   (mid_empty),
      .rd_data (mid_rd)
   );

   assign back_ctl   = tisp_pkg::ctl_type'(mid_rd[MID_WIDTH-1:VALUE_WIDTH]);
   assign back_value = mid_rd[VALUE_WIDTH-1:0];

   tisp_back #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (!mid_empty),
      .item_ctl   (back_ctl),
      .item_value (back_value),
      .item_take  (back_take),
      .res_full   (res_full),
      .res_push   (res_push),
      .res_kind   (res_kind),
      .res_value  (res_value)
   );

   // result queue keeps the back stage running while the receiver stalls
   tisp_queue #(
      .WIDTH (tisp_pkg::RSP_WIDTH),
      .DEPTH (tisp_pkg::QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (res_push),
      .full    (res_full),
      .wr_data ({res_kind, res_value}),
      .pop     (rsp_pop),
      .empty   (rsp_empty),
      .rd_data (rsp_rd)
   );

   assign rsp_result_kind  = rsp_rd[tisp_pkg::RSP_WIDTH-1:tisp_pkg::IN_VALUE_WIDTH];
   assign rsp_result_value = signed'(rsp_rd[tisp_pkg::IN_VALUE_WIDTH-1:0]);

endmodule

FILE: rtl/tisp_queue.sv
// small register-based fifo used between the stages
module tisp_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rd_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: rtl/tisp_front.sv
// front stage: classifies an incoming operand
module tisp_front #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                 operation,
   input  logic [tisp_pkg::KIND_WIDTH-1:0]      operand_kind,
   input  logic signed [tisp_pkg::IN_VALUE_WIDTH-1:0] operand_value,
   input  logic                                 first_operand,
   input  logic                                 last_operand,
   output tisp_pkg::ctl_type                    ctl,
   output logic [VALUE_WIDTH-1:0]               value
);

   tisp_pkg::kind_type kind;

   // out-of-range kind codes count as error
   always_comb begin
      case (operand_kind) inside
         [tisp_pkg::KIND_NORMAL:tisp_pkg::KIND_ERROR]:
            kind = tisp_pkg::kind_type'(operand_kind);
         default: kind = tisp_pkg::KIND_ERROR;
      endcase
   end

   // sign-extend or cut to the accumulator width
   assign value = VALUE_WIDTH'(operand_value);

   always_comb begin
      ctl.op      = tisp_pkg::op_type'(operation);
      ctl.kind    = kind;
      // zero counts as a negative infinity
      ctl.inf_neg = operand_value[tisp_pkg::IN_VALUE_WIDTH-1] || (operand_value == '0);
      ctl.is_zero = (value == '0);
      ctl.first   = first_operand;
      ctl.last    = last_operand;
   end

endmodule

FILE: rtl/tisp_back.sv
// back stage: reduction state machine and result forming
`include "tagged_int_sum_product_reduce_macros.svh"

module tisp_back #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  item_valid,
   input  tisp_pkg::ctl_type                     item_ctl,
   input  logic [VALUE_WIDTH-1:0]                item_value,
   output logic                                  item_take,
   input  logic                                  res_full,
   output logic                                  res_push,
   output tisp_pkg::kind_type                    res_kind,
   output logic [tisp_pkg::IN_VALUE_WIDTH-1:0]   res_value
);

   tisp_pkg::phase_type    phase_ff, phase_in, phase_s, phase_x;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in, acc_s, acc_x, product;
   logic                   unk_ff, unk_in, unk_s, unk_x;
   tisp_pkg::kind_type     fkind_ff, fkind_in, fkind_s, fkind_x;
   tisp_pkg::op_type       op_ff, op_in, op_s;
   logic                   acc_neg, ones;
   logic                   run_clear, inf_phase, acc_unit;

   assign item_take = item_valid && !(item_ctl.last && res_full);
   assign res_push  = item_take && item_ctl.last;

   // state seen by this operand, after a run start
   always_comb begin
      if (item_ctl.first) begin
         phase_s = tisp_pkg::PHASE_FINITE;
         unk_s   = 1'b0;
         fkind_s = tisp_pkg::KIND_NORMAL;
         op_s    = item_ctl.op;
         acc_s   = (item_ctl.op == tisp_pkg::OP_PRODUCT) ? VALUE_WIDTH'(1) : '0;
      end else begin
         phase_s = phase_ff;
         unk_s   = unk_ff;
         fkind_s = fkind_ff;
         op_s    = op_ff;
         acc_s   = acc_ff;
      end
   end

   assign acc_neg = acc_s[VALUE_WIDTH-1];
   assign product = acc_s * item_value;
   assign ones    = 1'b1;

   always_comb begin
      phase_x = phase_s;
      unk_x   = unk_s;
      fkind_x = fkind_s;
      acc_x   = acc_s;
      if (op_s == tisp_pkg::OP_SUM) begin
         case (phase_s)
            tisp_pkg::PHASE_FINITE: begin
               case (item_ctl.kind)
                  tisp_pkg::KIND_NORMAL: acc_x = acc_s + item_value;
                  tisp_pkg::KIND_INF: begin
                     unk_x   = 1'b0;
                     acc_x   = item_ctl.inf_neg ? {VALUE_WIDTH{ones}} : VALUE_WIDTH'(1);
                     phase_x = tisp_pkg::PHASE_INF;
                  end
                  tisp_pkg::KIND_UNKNOWN: unk_x = 1'b1;
                  default: begin
                     phase_x = tisp_pkg::PHASE_DONE;
                     fkind_x = item_ctl.kind;
                  end
               endcase
            end
            tisp_pkg::PHASE_INF: begin
               case (item_ctl.kind)
                  tisp_pkg::KIND_INF: begin
                     // opposite signs cancel into an error
                     if (acc_neg != item_ctl.inf_neg) begin
                        phase_x = tisp_pkg::PHASE_DONE;
                        fkind_x = tisp_pkg::KIND_ERROR;
                     end
                  end
                  tisp_pkg::KIND_NULL, tisp_pkg::KIND_ERROR: begin
                     phase_x = tisp_pkg::PHASE_DONE;
                     fkind_x = item_ctl.kind;
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end else begin
         case (phase_s)
            tisp_pkg::PHASE_FINITE: begin
               case (item_ctl.kind)
                  tisp_pkg::KIND_NORMAL: begin
                     if (item_ctl.is_zero) begin
                        acc_x   = '0;
                        unk_x   = 1'b0;
                        phase_x = tisp_pkg::PHASE_ZERO;
                     end else begin
                        acc_x = product;
                     end
                  end
                  tisp_pkg::KIND_INF: begin
                     acc_x   = (acc_neg != item_ctl.inf_neg) ? {VALUE_WIDTH{ones}}
                                                             : VALUE_WIDTH'(1);
                     phase_x = tisp_pkg::PHASE_INF;
                  end
                  tisp_pkg::KIND_UNKNOWN: unk_x = 1'b1;
                  default: begin
                     phase_x = tisp_pkg::PHASE_DONE;
                     fkind_x = item_ctl.kind;
                  end
               endcase
            end
            tisp_pkg::PHASE_INF: begin
               case (item_ctl.kind)
                  tisp_pkg::KIND_NORMAL: begin
                     if (item_ctl.is_zero) begin
                        phase_x = tisp_pkg::PHASE_DONE;
                        fkind_x = tisp_pkg::KIND_ERROR;
                     end else if (item_value[VALUE_WIDTH-1]) begin
                        acc_x = '0 - acc_s;
                     end
                  end
                  tisp_pkg::KIND_INF: begin
                     if (item_ctl.inf_neg) begin
                        acc_x = '0 - acc_s;
                     end
                  end
                  tisp_pkg::KIND_UNKNOWN: unk_x = 1'b1;
                  default: begin
                     phase_x = tisp_pkg::PHASE_DONE;
                     fkind_x = item_ctl.kind;
                  end
               endcase
            end
            tisp_pkg::PHASE_ZERO: begin
               case (item_ctl.kind)
                  tisp_pkg::KIND_INF: begin
                     phase_x = tisp_pkg::PHASE_DONE;
                     fkind_x = tisp_pkg::KIND_ERROR;
                  end
                  tisp_pkg::KIND_NULL, tisp_pkg::KIND_ERROR: begin
                     phase_x = tisp_pkg::PHASE_DONE;
                     fkind_x = item_ctl.kind;
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
   end

   // result of the run, taken on its last operand
   always_comb begin
      res_value = '0;
      if (phase_x == tisp_pkg::PHASE_DONE) begin
         res_kind = fkind_x;
      end else if (unk_x) begin
         res_kind = tisp_pkg::KIND_UNKNOWN;
      end else begin
         res_kind  = (phase_x == tisp_pkg::PHASE_INF) ? tisp_pkg::KIND_INF
                                                      : tisp_pkg::KIND_NORMAL;
         res_value = tisp_pkg::IN_VALUE_WIDTH'(signed'(acc_x));
      end
   end

   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      unk_in   = unk_ff;
      fkind_in = fkind_ff;
      op_in    = op_ff;
      if (item_take) begin
         if (item_ctl.last) begin
            phase_in = tisp_pkg::PHASE_FINITE;
            acc_in   = '0;
            unk_in   = 1'b0;
            fkind_in = tisp_pkg::KIND_NORMAL;
            op_in    = tisp_pkg::OP_SUM;
         end else begin
            phase_in = phase_x;
            acc_in   = acc_x;
            unk_in   = unk_x;
            fkind_in = fkind_x;
            op_in    = op_s;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= tisp_pkg::PHASE_FINITE;
         acc_ff   <= '0;
         unk_ff   <= 1'b0;
         fkind_ff <= tisp_pkg::KIND_NORMAL;
         op_ff    <= tisp_pkg::OP_SUM;
      end else begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         unk_ff   <= unk_in;
         fkind_ff <= fkind_in;
         op_ff    <= op_in;
      end
   end

   // terms for the checks below
   assign run_clear = (phase_ff == tisp_pkg::PHASE_FINITE) && !unk_ff &&
                      (op_ff == tisp_pkg::OP_SUM) && (acc_ff == '0);
   assign inf_phase = (phase_ff == tisp_pkg::PHASE_INF);
   assign acc_unit  = (acc_ff == VALUE_WIDTH'(1)) || (acc_ff == {VALUE_WIDTH{1'b1}});

   `TISP_ASSERT_NEXT(a_last_clears_run, clock, reset, res_push, run_clear, "run not cleared")
   `TISP_ASSERT_SAME(a_push_has_room, clock, reset, res_push, !res_full, "push into full queue")
   `TISP_ASSERT_SAME(a_inf_acc_unit, clock, reset, inf_phase, acc_unit, "acc not a unit sign")

endmodule
